@@ src/sa16_pkg.sv @@
// ----------------------------------------------------------------------------
// sa16_pkg
// Types, operation codes and the factorial table for the signed 16-bit ALU.
// ----------------------------------------------------------------------------
package sa16_pkg;

  localparam int unsigned OpW   = 16;
  localparam int unsigned ResW  = 32;
  localparam int unsigned CntW  = 4;
  localparam logic [OpW-1:0] FactLimit = 16'd12;

  typedef enum logic [2:0] {
    FN_ADD  = 3'd0,
    FN_SUB  = 3'd1,
    FN_MUL  = 3'd2,
    FN_FACT = 3'd3,
    FN_DIV  = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0]            func;
    logic signed [OpW-1:0] operand_a;
    logic signed [OpW-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [ResW-1:0] value;
    logic                   overflow;
    logic                   div_by_zero;
  } out_item_t;

  function automatic logic [ResW-1:0] fact_lut(input logic [3:0] n);
    logic [ResW-1:0] f;
    unique case (n)
      4'd0:    f = 32'd1;
      4'd1:    f = 32'd1;
      4'd2:    f = 32'd2;
      4'd3:    f = 32'd6;
      4'd4:    f = 32'd24;
      4'd5:    f = 32'd120;
      4'd6:    f = 32'd720;
      4'd7:    f = 32'd5040;
      4'd8:    f = 32'd40320;
      4'd9:    f = 32'd362880;
      4'd10:   f = 32'd3628800;
      4'd11:   f = 32'd39916800;
      4'd12:   f = 32'd479001600;
      default: f = 32'd0;
    endcase
    return f;
  endfunction

  function automatic logic [OpW-1:0] mag16(input logic [OpW-1:0] v);
    return v[OpW-1] ? (~v + 16'd1) : v;
  endfunction

endpackage

@@ src/sa16_mul.sv @@
// ----------------------------------------------------------------------------
// sa16_mul
// Unsigned 16x16 radix-2 shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sa16_mul
  import sa16_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [OpW-1:0]      mcand,
  input  logic [OpW-1:0]      mplier,
  output logic                busy,
  output logic                done,
  output logic [ResW-1:0]     product
);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [ResW-1:0] prod_r, prod_nxt;
  logic [OpW-1:0]  mcand_r, mcand_nxt;
  logic [OpW:0]    upper;

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    mcand_nxt = mcand_r;
    upper     = {1'b0, prod_r[ResW-1:OpW]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      prod_nxt  = {{OpW{1'b0}}, mplier};
      mcand_nxt = mcand;
    end else if (busy_r) begin
      prod_nxt = {upper, prod_r[OpW-1:1]};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    mcand_r <= mcand_nxt;
  end

  assign busy    = busy_r;
  assign done    = done_r;
  assign product = prod_r;

endmodule

@@ src/sa16_div.sv @@
// ----------------------------------------------------------------------------
// sa16_div
// Unsigned 16-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sa16_div
  import sa16_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [OpW-1:0] dividend,
  input  logic [OpW-1:0] divisor,
  output logic           busy,
  output logic           done,
  output logic [OpW-1:0] quotient
);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [OpW-1:0]  rem_r, rem_nxt;
  logic [OpW-1:0]  quo_r, quo_nxt;
  logic [OpW-1:0]  dvs_r, dvs_nxt;
  logic [OpW:0]    diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    diff     = {rem_r, quo_r[OpW-1]} - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[OpW]) begin
        rem_nxt = diff[OpW-1:0];
        quo_nxt = {quo_r[OpW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[OpW-2:0], quo_r[OpW-1]};
        quo_nxt = {quo_r[OpW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == '1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ src/signed_alu_16bit.sv @@
// ----------------------------------------------------------------------------
// signed_alu_16bit
// Signed 16-bit ALU: add, subtract, multiply, factorial, divide.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries func, operand_a, operand_b.
// Result channel out_valid/out_stall/out_data carries value, overflow and
// div_by_zero, exactly one result per accepted item.
// One item is in work at a time; in_stall is high from acceptance until the
// result moves into the output register.
// Add, subtract, factorial, unused codes and divide by zero: the result is
// formed into the work register at acceptance, then moves to the output
// register. Multiply and divide: 16 steps of a bit-serial shift-add or
// restoring unit fill the work register, then the result moves on; no new
// item is taken until the result has left the work register.
// The output register holds its item while out_stall is high; a finished
// result waits in the work register until the output register frees, and
// the next item can be accepted while the previous result is still held.
// Synchronous active-low reset empties the block; no clearing pass.
// ----------------------------------------------------------------------------
module signed_alu_16bit
  import sa16_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t    state_r, state_nxt;
  logic      neg_r, neg_nxt;
  logic      is_div_r, is_div_nxt;
  out_item_t res_r, res_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic            accept;
  logic [OpW-1:0]  mag_a, mag_b;
  logic [OpW:0]    sum17;
  logic            fact_oor;
  logic            mul_start, div_start;
  logic            mul_busy, mul_done, div_busy, div_done;
  logic [ResW-1:0] product;
  logic [OpW-1:0]  quotient, q16;
  logic            out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign mag_a    = mag16(in_data.operand_a);
  assign mag_b    = mag16(in_data.operand_b);
  assign fact_oor = in_data.operand_a[OpW-1] ||
                    ($unsigned(in_data.operand_a) > FactLimit);
  assign mul_start = accept && (in_data.func == FN_MUL);
  assign div_start = accept && (in_data.func == FN_DIV) && (in_data.operand_b != '0);
  assign q16      = neg_r ? (~quotient + 16'd1) : quotient;
  assign out_free = !out_valid_r || !out_stall;

  sa16_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mag_a),
    .mplier  (mag_b),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (product)
  );

  sa16_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    is_div_nxt    = is_div_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    sum17         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt    = '0;
          neg_nxt    = in_data.operand_a[OpW-1] ^ in_data.operand_b[OpW-1];
          is_div_nxt = (in_data.func == FN_DIV);
          state_nxt  = ST_DONE;
          unique case (in_data.func)
            FN_ADD, FN_SUB: begin
              if (in_data.func == FN_ADD) begin
                sum17 = {in_data.operand_a[OpW-1], in_data.operand_a} +
                        {in_data.operand_b[OpW-1], in_data.operand_b};
              end else begin
                sum17 = {in_data.operand_a[OpW-1], in_data.operand_a} -
                        {in_data.operand_b[OpW-1], in_data.operand_b};
              end
              res_nxt.value    = {{(ResW-OpW){sum17[OpW-1]}}, sum17[OpW-1:0]};
              res_nxt.overflow = sum17[OpW] ^ sum17[OpW-1];
            end
            FN_MUL: begin
              state_nxt = ST_RUN;
            end
            FN_FACT: begin
              if (fact_oor) begin
                res_nxt.overflow = 1'b1;
              end else begin
                res_nxt.value = fact_lut(in_data.operand_a[3:0]);
              end
            end
            FN_DIV: begin
              if (in_data.operand_b == '0) begin
                res_nxt.div_by_zero = 1'b1;
              end else begin
                state_nxt = ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        if (is_div_r && div_done) begin
          res_nxt.value = {{(ResW-OpW){q16[OpW-1]}}, q16};
          state_nxt     = ST_DONE;
        end else if (!is_div_r && mul_done) begin
          res_nxt.value = neg_r ? (~product + 32'd1) : product;
          state_nxt     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    is_div_r   <= is_div_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_unit_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_start || div_start) |-> (!mul_busy && !div_busy))
    else $error("serial unit started while busy");

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_done || div_done) |-> (state_r == ST_RUN))
    else $error("serial unit finished outside run state");

  a_run_has_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (mul_busy || div_busy || mul_done || div_done))
    else $error("run state with no unit at work");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.overflow && out_data.div_by_zero))
    else $error("overflow and divide-by-zero both set");
`endif

endmodule

@@ test/alu_result_checker.sv @@
// ----------------------------------------------------------------------------
// alu_result_checker
// Watches both channels of the signed 16-bit ALU. For every accepted item it
// computes the expected value, overflow and divide-by-zero flags and queues
// them. Each accepted result is compared field by field with the oldest
// queued entry. Hands the failure count and queue depth to the top.
// ----------------------------------------------------------------------------
module alu_result_checker
  import sa16_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_cnt,
  output int        pending_cnt
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ReportLimit = 10;

  out_item_t pending_results[$];
  int        fails;
  int        result_idx;

  initial begin
    fail_cnt    = 0;
    pending_cnt = 0;
    fails       = 0;
    result_idx  = 0;
  end

  function automatic logic [ResW-1:0] sext16(input int v);
    return {{(ResW-OpW){v[OpW-1]}}, v[OpW-1:0]};
  endfunction

  function automatic out_item_t alu_result_of(input in_item_t it);
    out_item_t       r;
    int              a;
    int              b;
    int              acc;
    int              i;
    logic [ResW-1:0] fact;
    a = it.operand_a;
    b = it.operand_b;
    r = '0;
    case (it.func)
      FN_ADD, FN_SUB: begin
        acc = (it.func == FN_ADD) ? a + b : a - b;
        r.value    = sext16(acc);
        r.overflow = (acc > 32767) || (acc < -32768);
      end
      FN_MUL: begin
        r.value = a * b;
      end
      FN_FACT: begin
        if (a < 0 || a > int'(FactLimit)) begin
          r.overflow = 1'b1;
        end else begin
          fact = 1;
          for (i = 2; i <= a; i++) fact = fact * i;
          r.value = fact;
        end
      end
      FN_DIV: begin
        if (b == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          acc     = a / b;
          r.value = sext16(acc);
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) pending_results.push_back(alu_result_of(in_data));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          fails++;
          if (fails <= ReportLimit)
            $display("result %0d arrived with nothing expected: value=%0d ovf=%0b dbz=%0b",
                     result_idx, out_data.value, out_data.overflow, out_data.div_by_zero);
        end else begin
          want = pending_results.pop_front();
          if (out_data.value !== want.value || out_data.overflow !== want.overflow ||
              out_data.div_by_zero !== want.div_by_zero) begin
            fails++;
            if (fails <= ReportLimit) begin
              $display("result %0d mismatch: expected value=%0d ovf=%0b dbz=%0b",
                       result_idx, want.value, want.overflow, want.div_by_zero);
              $display("result %0d mismatch: got      value=%0d ovf=%0b dbz=%0b",
                       result_idx, out_data.value, out_data.overflow,
                       out_data.div_by_zero);
            end
          end
        end
        result_idx++;
      end
      fail_cnt    <= fails;
      pending_cnt <= pending_results.size();
    end
  end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Top level for the signed 16-bit ALU. Drives directed corner items (add and
// subtract overflow, extreme products, factorial range edges, divide by zero,
// most negative over minus one, unused codes) and then random items, with
// random gaps on the input side and random stalls on the result side. The
// checker beside the block predicts and compares; the top gives the verdict.
// ----------------------------------------------------------------------------
module testbench
  import sa16_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 800;
  localparam int NumCodes  = 8;
  localparam int MinOp     = -32768;
  localparam int MaxOp     = 32767;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_cnt;
  int        pending_cnt;
  bit        calm = 1'b0;
  int        stall_hold = 0;

  always #5 clk = ~clk;

  signed_alu_16bit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  alu_result_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(15, 50);
  endfunction

  function automatic in_item_t make_item(input logic [2:0] f, input int a, input int b);
    in_item_t it;
    it.func      = f;
    it.operand_a = a[OpW-1:0];
    it.operand_b = b[OpW-1:0];
    return it;
  endfunction

  function automatic int rand_operand();
    case ($urandom_range(0, 9))
      0:       return MinOp;
      1:       return MaxOp;
      2:       return int'($urandom_range(0, 16)) - 8;
      3:       return int'($urandom_range(0, 255)) - 128;
      default: return int'($urandom_range(0, 65535)) + MinOp;
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // result-side backpressure
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold = stall_hold - 1;
    end else begin
      out_stall <= rst_n && !calm && ($urandom_range(0, 2) == 0);
      stall_hold = idle_len();
    end
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [2:0] f;
    int         a;
    int         b;
    int         code;
    int         n;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(make_item(FN_ADD, MaxOp, MaxOp));
    send_item(make_item(FN_ADD, MinOp, MinOp));
    send_item(make_item(FN_ADD, MaxOp, 1));
    send_item(make_item(FN_ADD, -1, 1));
    send_item(make_item(FN_SUB, MinOp, 1));
    send_item(make_item(FN_SUB, 0, MinOp));
    send_item(make_item(FN_SUB, MaxOp, MaxOp));
    send_item(make_item(FN_MUL, MinOp, MinOp));
    send_item(make_item(FN_MUL, MaxOp, MinOp));
    send_item(make_item(FN_MUL, -1, -1));
    send_item(make_item(FN_MUL, MaxOp, 0));
    send_item(make_item(FN_FACT, 0, MinOp));
    send_item(make_item(FN_FACT, 12, 5));
    send_item(make_item(FN_FACT, 13, 0));
    send_item(make_item(FN_FACT, -1, 0));
    send_item(make_item(FN_FACT, MinOp, MaxOp));
    send_item(make_item(FN_DIV, 5, 0));
    send_item(make_item(FN_DIV, MinOp, -1));
    send_item(make_item(FN_DIV, -7, 2));
    send_item(make_item(FN_DIV, 7, -2));
    send_item(make_item(FN_DIV, MaxOp, MinOp));
    send_item(make_item(FN_DIV, MinOp, MinOp));
    for (code = FN_DIV + 1; code < NumCodes; code++)
      send_item(make_item(code[2:0], MaxOp, MinOp));

    for (n = 0; n < NumRandom; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) code = $urandom_range(FN_DIV + 1, NumCodes - 1);
      else code = $urandom_range(FN_ADD, FN_DIV);
      f = code[2:0];
      a = rand_operand();
      b = rand_operand();
      if (f == FN_FACT && $urandom_range(0, 4) != 0) a = int'($urandom_range(0, 15)) - 2;
      if (f == FN_DIV && $urandom_range(0, 6) == 0) b = 0;
      send_item(make_item(f, a, b));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    calm = 1'b1;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ signed_alu_16bit.f @@
src/sa16_pkg.sv
src/sa16_mul.sv
src/sa16_div.sv
src/signed_alu_16bit.sv
test/alu_result_checker.sv
test/testbench.sv
